@@ rtl/cgs_pkg.sv @@
// Shared types, widths and helpers for the column group shrinkage block.
// No dependencies; used by every module in rtl/.
package cgs_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int COLUMN_DEPTH  = 32;
  localparam int THRESH_W      = 18;
  localparam int INDEX_W       = 6;

  localparam int ADDR_W  = (COLUMN_DEPTH > 1) ? $clog2(COLUMN_DEPTH) : 1;
  localparam int COUNT_W = $clog2(COLUMN_DEPTH + 1);
  localparam int MAG_W   = ELEMENT_WIDTH;
  // each square is at most 2^(2*ELEMENT_WIDTH-2), times the column depth
  localparam int SUM_W   = 2 * ELEMENT_WIDTH - 2 + COUNT_W;
  localparam int ROOT_W  = (SUM_W + 1) / 2;

  // divider retires DIV_BITS quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (MAG_W + DIV_BITS - 1) / DIV_BITS;
  localparam int QUO_W     = DIV_STEPS * DIV_BITS;
  localparam int NUM_W     = ROOT_W + QUO_W;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] element_value;
    logic                            column_end;
  } elem_in_t;

  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] shrunk_value;
    logic [INDEX_W-1:0]              element_index;
    logic                            last_of_column;
    logic                            overflow_dropped;
  } elem_out_t;

  // magnitude of a two's complement element; the most negative value fits unsigned
  function automatic logic [MAG_W-1:0] elem_mag(input logic [ELEMENT_WIDTH-1:0] x);
    logic [MAG_W-1:0] m;
    m = x[ELEMENT_WIDTH-1] ? (~x + 1'b1) : x;
    return m;
  endfunction

endpackage

@@ rtl/cgs_isqrt.sv @@
// Digit-by-digit floored square root, one root bit per cycle.
// Depends on cgs_pkg for SUM_W and ROOT_W.
module cgs_isqrt
  import cgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W:0]     rem;
  logic [CNT_W-1:0]    step;
  logic                busy;

  logic [ROOT_W+2:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   rem_sub;
  logic                take;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh  = {rem, rad[2*ROOT_W-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    take    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rad  <= (2*ROOT_W)'(radicand);
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[2*ROOT_W-3:0], 2'b00};
        rem  <= take ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
        root <= {root[ROOT_W-2:0], take};
        step <= step + 1'b1;
        if (step == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/cgs_div.sv @@
// Restoring divider for the element scaling, DIV_BITS quotient bits per cycle.
// Depends on cgs_pkg; the caller guarantees the quotient fits in QUO_W bits.
module cgs_div
  import cgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  numer,
  input  logic [ROOT_W-1:0] denom,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // remainder in the top ROOT_W bits, dividend then quotient shifting below
  logic [NUM_W-1:0]  acc;
  logic [NUM_W-1:0]  acc_next;
  logic [CNT_W-1:0]  step;
  logic              busy;

  // run DIV_BITS compare-subtract steps
  always_comb begin
    logic [ROOT_W:0] t;
    logic            q;
    acc_next = acc;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {acc_next[NUM_W-1 -: ROOT_W], acc_next[QUO_W-1]};
      q = (t >= {1'b0, denom});
      if (q) begin
        t = t - {1'b0, denom};
      end
      acc_next = {t[ROOT_W-1:0], acc_next[QUO_W-2:0], q};
    end
  end

  assign quotient = acc[QUO_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        acc  <= numer;
      end else if (busy) begin
        acc  <= acc_next;
        step <= step + 1'b1;
        if (step == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/column_group_shrinkage_core.sv @@
// Column group soft-thresholding: buffers a column, takes its l2 norm, rescales.
// Depends on cgs_pkg, cgs_isqrt and cgs_div.
//
// Elements of one column stream in at one word per cycle and are written into a
// 32-entry column memory while their squares are summed. The word marked as
// column end stalls the input until the whole column has been sent out: a start
// state for the root, the bit-serial square root of 18 root bits, then per stored
// element a memory read, the multiply, the divider and the output, plus any wait
// while the output is stalled.
// Elements past the memory depth are dropped and the column's results carry
// overflow_dropped. The threshold register is written through the cfg channel,
// which is always ready; write it only while idle.
module column_group_shrinkage_core
  import cgs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [THRESH_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  elem_in_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output elem_out_t           out_word
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROOT_GO,
    ST_ROOT,
    ST_FETCH,
    ST_SCALE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t              state;
  logic [THRESH_W-1:0] shrink_threshold;
  logic [COUNT_W-1:0]  element_count;
  logic [SUM_W-1:0]    square_sum;
  logic                dropped_flag;

  logic [ELEMENT_WIDTH-1:0] column_store [COLUMN_DEPTH];
  logic [ELEMENT_WIDTH-1:0] mem_q;
  logic [ADDR_W-1:0]        rd_idx;

  logic [ROOT_W-1:0]   norm;
  logic [ROOT_W-1:0]   diff;
  logic                pass;
  logic                neg;

  logic                in_acc;
  logic                room;
  logic [MAG_W-1:0]    in_mag;
  logic [SUM_W-1:0]    sum_next;
  logic [MAG_W-1:0]    rd_mag;
  logic [NUM_W-1:0]    numer;
  logic                is_last;
  logic [ELEMENT_WIDTH-1:0] scaled;

  logic                root_done;
  logic [ROOT_W-1:0]   root_val;
  logic                div_done;
  logic [QUO_W-1:0]    quo;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign room      = (element_count < COUNT_W'(COLUMN_DEPTH));

  // accumulate the square of each stored element
  always_comb begin
    in_mag   = elem_mag(in_word.element_value);
    sum_next = square_sum + SUM_W'(in_mag) * SUM_W'(in_mag);
  end

  // scale the fetched element; multiplier output is registered by the divider
  always_comb begin
    rd_mag  = elem_mag(mem_q);
    numer   = NUM_W'(rd_mag) * NUM_W'(diff);
    is_last = (COUNT_W'(rd_idx) + 1'b1 == element_count);
    scaled  = '0;
    if (pass) begin
      scaled = neg ? ELEMENT_WIDTH'(~quo + 1'b1) : ELEMENT_WIDTH'(quo);
    end
  end

  // column memory: one write port on load, one registered read on fetch
  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      column_store[element_count[ADDR_W-1:0]] <= in_word.element_value;
    end
    if (state == ST_FETCH) begin
      mem_q <= column_store[rd_idx];
    end
  end

  cgs_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_ROOT_GO),
    .radicand (square_sum),
    .done     (root_done),
    .root     (root_val)
  );

  cgs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_SCALE),
    .numer    (numer),
    .denom    (norm),
    .done     (div_done),
    .quotient (quo)
  );

  // sequencer: load, root, then replay each stored element
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_LOAD;
      shrink_threshold <= '0;
      element_count    <= '0;
      square_sum       <= '0;
      dropped_flag     <= 1'b0;
      out_valid        <= 1'b0;
      rd_idx           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        shrink_threshold <= cfg_data;
      end
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              element_count <= element_count + 1'b1;
              square_sum    <= sum_next;
            end else begin
              dropped_flag <= 1'b1;
            end
            if (in_word.column_end) begin
              state <= ST_ROOT_GO;
            end
          end
        end
        ST_ROOT_GO: begin
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (root_done) begin
            norm   <= root_val;
            pass   <= (root_val > shrink_threshold);
            diff   <= root_val - shrink_threshold;
            rd_idx <= '0;
            if (element_count == '0) begin
              square_sum   <= '0;
              dropped_flag <= 1'b0;
              state        <= ST_LOAD;
            end else begin
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          neg   <= mem_q[ELEMENT_WIDTH-1];
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_done) begin
            out_valid                 <= 1'b1;
            out_word.shrunk_value     <= scaled;
            out_word.element_index    <= INDEX_W'(rd_idx);
            out_word.last_of_column   <= is_last;
            out_word.overflow_dropped <= dropped_flag;
            state                     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (out_word.last_of_column) begin
              element_count <= '0;
              square_sum    <= '0;
              dropped_flag  <= 1'b0;
              state         <= ST_LOAD;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= ST_FETCH;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // the store never holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    element_count <= COUNT_W'(COLUMN_DEPTH))
    else $error("element count beyond column depth");

  // a result only ever comes from a stored element
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (element_count != '0) &&
                  (COUNT_W'(out_word.element_index) < element_count))
    else $error("result index outside the stored column");

  // a column at or under the threshold yields only zeros
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pass) |-> (out_word.shrunk_value == '0))
    else $error("nonzero result for a column under the threshold");

  // taking the last word of a column clears the column state
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_word.last_of_column) |=>
      (element_count == '0) && (square_sum == '0) && !dropped_flag && !out_valid)
    else $error("column state not cleared after the last word");

  // input is held off from the column end until the last word goes out
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while results are pending");

endmodule
